@@ sv/iesg_pkg.sv @@
// ----------------------------------------------------------------------------
// iesg_pkg
// Shared types, widths and register codes of the isotropic elastic stress core.
// ----------------------------------------------------------------------------
`default_nettype none

package iesg_pkg;

  // datapath widths
  localparam int unsigned SUM_W     = 49;  // signed weighted strain sum
  localparam int unsigned MAG_W     = 48;  // magnitude of that sum
  localparam int unsigned NUM_W     = 88;  // dividend e * |s|
  localparam int unsigned DIV_W     = 47;  // divisor width
  localparam int unsigned DIV_STEPS = 57;  // quotient bits, one per stage
  localparam int unsigned LANES     = 6;   // xx, yy, zz, xy, xz, yz
  localparam int unsigned RES_W     = 48;  // stress width

  // lane order
  localparam int unsigned LANE_XX = 0;
  localparam int unsigned LANE_YY = 1;
  localparam int unsigned LANE_ZZ = 2;
  localparam int unsigned LANE_XY = 3;
  localparam int unsigned LANE_XZ = 4;
  localparam int unsigned LANE_YZ = 5;

  // configuration port
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 40;

  localparam logic [CFG_IDX_W-1:0] CFG_YOUNGS    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_POISSON   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ALPHA     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TREF      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_TEMP_EN   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_STRESS_EN = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_THREE_D   = 3'd6;

  // register reset values
  localparam logic [39:0] RST_YOUNGS  = 40'd15000000000;
  localparam logic [14:0] RST_POISSON = 15'd13107;
  localparam logic [31:0] RST_ALPHA   = 32'd1099512;
  localparam logic [27:0] RST_TREF    = 28'd19211878;

  typedef struct packed {
    logic signed [31:0] dux_dx;
    logic signed [31:0] dux_dy;
    logic signed [31:0] dux_dz;
    logic signed [31:0] duy_dx;
    logic signed [31:0] duy_dy;
    logic signed [31:0] duy_dz;
    logic signed [31:0] duz_dx;
    logic signed [31:0] duz_dy;
    logic signed [31:0] duz_dz;
    logic        [27:0] temperature_k;
  } in_t;

  typedef struct packed {
    logic signed [31:0] thermal_strain_out;
    logic signed [31:0] shear_strain_xy;
    logic signed [31:0] shear_strain_xz;
    logic signed [31:0] shear_strain_yz;
    logic signed [47:0] normal_stress_xx;
    logic signed [47:0] normal_stress_yy;
    logic signed [47:0] normal_stress_zz;
    logic signed [47:0] shear_stress_xy;
    logic signed [47:0] shear_stress_xz;
    logic signed [47:0] shear_stress_yz;
  } out_t;

  // results that bypass the dividers
  typedef struct packed {
    logic signed [31:0] thermal;
    logic signed [31:0] sh_xy;
    logic signed [31:0] sh_xz;
    logic signed [31:0] sh_yz;
  } side_t;

  typedef struct packed {
    logic [39:0] youngs;
    logic [14:0] poisson;
    logic [31:0] alpha;
    logic [27:0] tref;
    logic        temp_en;
    logic        stress_en;
    logic        three_d;
  } cfg_t;

  // pipeline control between stages
  typedef struct packed {
    logic adv;
    logic valid;
  } ctl_t;

endpackage

`default_nettype wire

@@ sv/iesg_front.sv @@
// ----------------------------------------------------------------------------
// iesg_front
// Front stages: input capture, strain sums and thermal product, split
// multiply by the modulus, dividend assembly.
// ----------------------------------------------------------------------------
`default_nettype none

module iesg_front (
  input  wire                                               clk_i,
  input  wire                                               rst_ni,
  input  wire iesg_pkg::ctl_t                               ctl_i,
  input  wire iesg_pkg::in_t                                data_i,
  input  wire iesg_pkg::cfg_t                               cfg_i,
  output logic                                              valid_o,
  output logic [iesg_pkg::LANES-1:0][iesg_pkg::NUM_W-1:0]   num_o,
  output logic [iesg_pkg::LANES-1:0]                        neg_o,
  output iesg_pkg::side_t                                   side_o
);

  localparam int unsigned SW = iesg_pkg::SUM_W;
  localparam int unsigned MW = iesg_pkg::MAG_W;
  localparam int unsigned HW = iesg_pkg::MAG_W / 2;
  localparam int unsigned NL = iesg_pkg::LANES;

  // stage a: input capture
  iesg_pkg::in_t a_q;
  logic          va_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
    end else if (ctl_i.adv) begin
      va_q <= ctl_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.adv) begin
      a_q <= data_i;
    end
  end

  // stage b: thermal product and weighted strain sums
  logic signed [28:0]           dt;
  logic [27:0]                  tmag;
  logic [59:0]                  tp_d;
  logic [16:0]                  k1;
  logic signed [SW-1:0]         k1s, k2s, exs, eys, ezs;
  logic [NL-1:0][SW-1:0]        s_d;
  logic                         d3;

  always_comb begin
    dt   = $signed({1'b0, a_q.temperature_k}) - $signed({1'b0, cfg_i.tref});
    tmag = dt[28] ? 28'(-dt) : dt[27:0];
    if (!cfg_i.temp_en) begin
      tmag = '0;
    end
    tp_d = {28'd0, cfg_i.alpha} * {32'd0, tmag};

    d3  = cfg_i.three_d;
    k1  = 17'h10000 - {2'b00, cfg_i.poisson};
    k1s = $signed({{(SW-17){1'b0}}, k1});
    k2s = $signed({{(SW-15){1'b0}}, cfg_i.poisson});
    exs = SW'(a_q.dux_dx);
    eys = SW'(a_q.duy_dy);
    ezs = d3 ? SW'(a_q.duz_dz) : '0;

    s_d[iesg_pkg::LANE_XX] = k1s * exs + k2s * (eys + ezs);
    s_d[iesg_pkg::LANE_YY] = k1s * eys + k2s * (exs + ezs);
    s_d[iesg_pkg::LANE_ZZ] = d3 ? k1s * ezs + k2s * (exs + eys) : '0;
    s_d[iesg_pkg::LANE_XY] = SW'(a_q.dux_dy) + SW'(a_q.duy_dx);
    s_d[iesg_pkg::LANE_XZ] = d3 ? SW'(a_q.dux_dz) + SW'(a_q.duz_dx) : '0;
    s_d[iesg_pkg::LANE_YZ] = d3 ? SW'(a_q.duy_dz) + SW'(a_q.duz_dy) : '0;
    if (!cfg_i.stress_en) begin
      s_d = '0;
    end
  end

  logic [NL-1:0][SW-1:0] s_q;
  logic [59:0]           tp_q;
  logic                  tneg_q;
  logic                  vb_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vb_q <= 1'b0;
    end else if (ctl_i.adv) begin
      vb_q <= va_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.adv) begin
      s_q    <= s_d;
      tp_q   <= tp_d;
      tneg_q <= dt[28];
    end
  end

  // stage c: split multiply by the modulus, thermal rounding
  logic [NL-1:0][63:0] pp0_d, pp1_d;
  logic [NL-1:0]       negc_d;
  logic [MW-1:0]       mag;
  logic [60:0]         tsum;
  logic [34:0]         tr, tlim;
  iesg_pkg::side_t     sidec_d;

  always_comb begin
    mag = '0;
    for (int i = 0; i < NL; i++) begin
      negc_d[i] = s_q[i][SW-1];
      mag       = negc_d[i] ? MW'(-s_q[i]) : s_q[i][MW-1:0];
      pp0_d[i]  = {24'd0, cfg_i.youngs} * {40'd0, mag[HW-1:0]};
      pp1_d[i]  = {24'd0, cfg_i.youngs} * {40'd0, mag[MW-1:HW]};
    end

    // round to nearest, ties away, then saturate
    tsum = {1'b0, tp_q} + 61'h2000000;
    tr   = tsum[60:26];
    tlim = tneg_q ? 35'h080000000 : 35'h07fffffff;
    if (tr > tlim) begin
      tr = tlim;
    end
    sidec_d.thermal = tneg_q ? 32'(-tr) : tr[31:0];
    sidec_d.sh_xy   = s_q[iesg_pkg::LANE_XY][32:1];
    sidec_d.sh_xz   = s_q[iesg_pkg::LANE_XZ][32:1];
    sidec_d.sh_yz   = s_q[iesg_pkg::LANE_YZ][32:1];
  end

  logic [NL-1:0][63:0] pp0_q, pp1_q;
  logic [NL-1:0]       negc_q;
  iesg_pkg::side_t     sidec_q;
  logic                vc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vc_q <= 1'b0;
    end else if (ctl_i.adv) begin
      vc_q <= vb_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.adv) begin
      pp0_q   <= pp0_d;
      pp1_q   <= pp1_d;
      negc_q  <= negc_d;
      sidec_q <= sidec_d;
    end
  end

  // stage d: dividend assembly
  logic [NL-1:0][iesg_pkg::NUM_W-1:0] num_d;

  always_comb begin
    for (int i = 0; i < NL; i++) begin
      num_d[i] = iesg_pkg::NUM_W'(pp0_q[i])
               + (iesg_pkg::NUM_W'(pp1_q[i]) << HW);
    end
  end

  logic vd_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vd_q <= 1'b0;
    end else if (ctl_i.adv) begin
      vd_q <= vc_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.adv) begin
      num_o  <= num_d;
      neg_o  <= negc_q;
      side_o <= sidec_q;
    end
  end

  assign valid_o = vd_q;

endmodule

`default_nettype wire

@@ sv/iesg_divlane.sv @@
// ----------------------------------------------------------------------------
// iesg_divlane
// Pipelined restoring divider, one quotient bit per stage, with
// round-to-nearest and 48-bit saturation on the way out.
// ----------------------------------------------------------------------------
`default_nettype none

module iesg_divlane (
  input  wire                                 clk_i,
  input  wire                                 adv_i,
  input  wire [iesg_pkg::NUM_W-1:0]           num_i,
  input  wire                                 neg_i,
  input  wire [iesg_pkg::DIV_W-1:0]           div_i,
  output logic signed [iesg_pkg::RES_W-1:0]   res_o
);

  localparam int unsigned DW = iesg_pkg::DIV_W;
  localparam int unsigned QW = iesg_pkg::DIV_STEPS;
  localparam int unsigned NS = iesg_pkg::DIV_STEPS;
  localparam int unsigned RW = iesg_pkg::RES_W;
  localparam int unsigned HI = iesg_pkg::NUM_W - QW;

  logic [DW-1:0] rem_q [NS];
  logic [QW-1:0] x_q   [NS];
  logic          neg_q [NS];

  // one quotient bit per stage; x holds dividend bits above, quotient below
  for (genvar k = 0; k < NS; k++) begin : g_step
    logic [DW-1:0] rem_in;
    logic [QW-1:0] x_in;
    logic          neg_in;
    logic [DW:0]   t;
    logic          ge;

    if (k == 0) begin : g_first
      assign rem_in = {{(DW-HI){1'b0}}, num_i[iesg_pkg::NUM_W-1:QW]};
      assign x_in   = num_i[QW-1:0];
      assign neg_in = neg_i;
    end else begin : g_next
      assign rem_in = rem_q[k-1];
      assign x_in   = x_q[k-1];
      assign neg_in = neg_q[k-1];
    end

    assign t  = {rem_in, x_in[QW-1]};
    assign ge = t >= {1'b0, div_i};

    always_ff @(posedge clk_i) begin
      if (adv_i) begin
        rem_q[k] <= ge ? DW'(t - {1'b0, div_i}) : t[DW-1:0];
        x_q[k]   <= {x_in[QW-2:0], ge};
        neg_q[k] <= neg_in;
      end
    end
  end

  // rounding and saturation
  logic        up;
  logic [QW:0] qr, lim, sat;

  always_comb begin
    up  = {rem_q[NS-1], 1'b0} >= {1'b0, div_i};
    qr  = {1'b0, x_q[NS-1]} + {{QW{1'b0}}, up};
    lim = neg_q[NS-1] ? (QW+1)'(1) << (RW-1) : ((QW+1)'(1) << (RW-1)) - 1'b1;
    sat = (qr > lim) ? lim : qr;
    res_o = neg_q[NS-1] ? RW'(-sat[RW-1:0]) : sat[RW-1:0];
  end

endmodule

`default_nettype wire

@@ sv/iesg_delay.sv @@
// ----------------------------------------------------------------------------
// iesg_delay
// Delay line that carries valid bits and the non-divided results alongside
// the divider stages.
// ----------------------------------------------------------------------------
`default_nettype none

module iesg_delay (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire iesg_pkg::ctl_t   ctl_i,
  input  wire iesg_pkg::side_t  side_i,
  output logic                  valid_o,
  output iesg_pkg::side_t       side_o
);

  localparam int unsigned NS = iesg_pkg::DIV_STEPS;

  logic [NS-1:0]   v_q;
  iesg_pkg::side_t sd_q [NS];

  // valid shift line
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (ctl_i.adv) begin
      v_q <= {v_q[NS-2:0], ctl_i.valid};
    end
  end

  // payload shift line
  always_ff @(posedge clk_i) begin
    if (ctl_i.adv) begin
      sd_q[0] <= side_i;
      for (int k = 1; k < NS; k++) begin
        sd_q[k] <= sd_q[k-1];
      end
    end
  end

  assign valid_o = v_q[NS-1];
  assign side_o  = sd_q[NS-1];

endmodule

`default_nettype wire

@@ sv/isotropic_elastic_stress_from_gradients_core.sv @@
// ----------------------------------------------------------------------------
// isotropic_elastic_stress_from_gradients_core
// Hooke's-law stresses, shear strains and thermal strain for one quadrature
// point per beat.
//
//   channel  direction  handshake            payload
//   in       sink       in_valid_i/in_stall_o  in_data_i  (iesg_pkg::in_t)
//   out      source     out_valid_o/out_stall_i out_data_o (iesg_pkg::out_t)
//   cfg      sink       cfg_valid_i/cfg_ready_o cfg_index_i, cfg_data_i
//
// one beat in and one beat out per cycle unless an output stall holds the
// pipeline; a result passes through four front stages, the 57-stage divider
// (one quotient bit per stage) and the output register
// reset clears valid bits and loads the register defaults; no clearing pass
// a stall on the output holds the whole pipeline; the output register lets a
// new beat in whenever the waiting result is taken in the same cycle
// ----------------------------------------------------------------------------
`default_nettype none

module isotropic_elastic_stress_from_gradients_core (
  input  wire                                   clk_i,
  input  wire                                   rst_ni,
  input  wire                                   in_valid_i,
  output logic                                  in_stall_o,
  input  wire iesg_pkg::in_t                    in_data_i,
  output logic                                  out_valid_o,
  input  wire                                   out_stall_i,
  output iesg_pkg::out_t                        out_data_o,
  input  wire                                   cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  wire [iesg_pkg::CFG_IDX_W-1:0]         cfg_index_i,
  input  wire [iesg_pkg::CFG_DATA_W-1:0]        cfg_data_i
);

  localparam int unsigned NL = iesg_pkg::LANES;
  localparam int unsigned DW = iesg_pkg::DIV_W;

  // configuration registers
  iesg_pkg::cfg_t cfg_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.youngs    <= iesg_pkg::RST_YOUNGS;
      cfg_q.poisson   <= iesg_pkg::RST_POISSON;
      cfg_q.alpha     <= iesg_pkg::RST_ALPHA;
      cfg_q.tref      <= iesg_pkg::RST_TREF;
      cfg_q.temp_en   <= 1'b0;
      cfg_q.stress_en <= 1'b0;
      cfg_q.three_d   <= 1'b0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        iesg_pkg::CFG_YOUNGS:    cfg_q.youngs    <= cfg_data_i[39:0];
        iesg_pkg::CFG_POISSON:   cfg_q.poisson   <= cfg_data_i[14:0];
        iesg_pkg::CFG_ALPHA:     cfg_q.alpha     <= cfg_data_i[31:0];
        iesg_pkg::CFG_TREF:      cfg_q.tref      <= cfg_data_i[27:0];
        iesg_pkg::CFG_TEMP_EN:   cfg_q.temp_en   <= cfg_data_i[0];
        iesg_pkg::CFG_STRESS_EN: cfg_q.stress_en <= cfg_data_i[0];
        iesg_pkg::CFG_THREE_D:   cfg_q.three_d   <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // divisors from the poisson ratio, refreshed every cycle
  logic [16:0]   na, nb;
  logic [33:0]   dprod;
  logic [DW-1:0] dn_q, ds_q;

  always_comb begin
    na    = 17'h10000 + {2'b00, cfg_q.poisson};
    nb    = 17'h10000 - {1'b0, cfg_q.poisson, 1'b0};
    dprod = {17'd0, na} * {17'd0, nb};
  end

  always_ff @(posedge clk_i) begin
    dn_q <= {dprod[32:0], 14'd0};
    ds_q <= {15'd0, na, 15'd0};
  end

  // pipeline advance
  logic           out_valid_q;
  logic           adv;
  iesg_pkg::ctl_t in_ctl, dly_ctl;

  assign adv        = !out_valid_q || !out_stall_i;
  assign in_stall_o = !adv;
  assign in_ctl     = '{adv: adv, valid: in_valid_i};

  // front stages
  logic                                   fr_valid;
  logic [NL-1:0][iesg_pkg::NUM_W-1:0]     fr_num;
  logic [NL-1:0]                          fr_neg;
  iesg_pkg::side_t                        fr_side;

  iesg_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (in_ctl),
    .data_i  (in_data_i),
    .cfg_i   (cfg_q),
    .valid_o (fr_valid),
    .num_o   (fr_num),
    .neg_o   (fr_neg),
    .side_o  (fr_side)
  );

  // divider lanes
  logic signed [iesg_pkg::RES_W-1:0] res [NL];

  for (genvar i = 0; i < NL; i++) begin : g_lane
    iesg_divlane u_lane (
      .clk_i (clk_i),
      .adv_i (adv),
      .num_i (fr_num[i]),
      .neg_i (fr_neg[i]),
      .div_i ((i < iesg_pkg::LANE_XY) ? dn_q : ds_q),
      .res_o (res[i])
    );
  end

  // side results and valid bits alongside the dividers
  logic            dly_valid;
  iesg_pkg::side_t dly_side;

  assign dly_ctl = '{adv: adv, valid: fr_valid};

  iesg_delay u_delay (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (dly_ctl),
    .side_i  (fr_side),
    .valid_o (dly_valid),
    .side_o  (dly_side)
  );

  // output register
  iesg_pkg::out_t out_d, out_q;

  always_comb begin
    out_d.thermal_strain_out = dly_side.thermal;
    out_d.shear_strain_xy    = dly_side.sh_xy;
    out_d.shear_strain_xz    = dly_side.sh_xz;
    out_d.shear_strain_yz    = dly_side.sh_yz;
    out_d.normal_stress_xx   = res[iesg_pkg::LANE_XX];
    out_d.normal_stress_yy   = res[iesg_pkg::LANE_YY];
    out_d.normal_stress_zz   = res[iesg_pkg::LANE_ZZ];
    out_d.shear_stress_xy    = res[iesg_pkg::LANE_XY];
    out_d.shear_stress_xz    = res[iesg_pkg::LANE_XZ];
    out_d.shear_stress_yz    = res[iesg_pkg::LANE_YZ];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= dly_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // checks
  a_stall_back: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |-> in_stall_o)
    else $error("output stall not passed back to the input");

  a_out_from_line: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(dly_valid))
    else $error("result beat appeared without a beat in the delay line");

endmodule

`default_nettype wire

@@ dv/iesg_stress_checker.sv @@
// ----------------------------------------------------------------------------
// iesg_stress_checker
// Watches the input, output and register channels of the elastic stress core.
// Every accepted input beat is turned into an expected result by a local model
// of Hooke's law. Each output beat is compared field by field with the oldest
// expected result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module iesg_stress_checker (
  input  wire                                clk_i,
  input  wire                                rst_ni,
  input  wire                                in_valid_i,
  input  wire                                in_stall_i,
  input  wire iesg_pkg::in_t                 in_data_i,
  input  wire                                out_valid_i,
  input  wire                                out_stall_i,
  input  wire iesg_pkg::out_t                out_data_i,
  input  wire                                cfg_valid_i,
  input  wire                                cfg_ready_i,
  input  wire [iesg_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  wire [iesg_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  output int unsigned                        fail_count_o,
  output int unsigned                        pending_o
);

  // local copy of the material registers
  logic [39:0] youngs_q;
  logic [14:0] poisson_q;
  logic [31:0] alpha_q;
  logic [27:0] tref_q;
  logic        temp_en_q;
  logic        stress_en_q;
  logic        three_d_q;

  iesg_pkg::out_t expected_results[$];

  // round e*s/d to nearest, ties away from zero, saturate to 48 bits
  function automatic logic [47:0] stress_quotient(logic [39:0] e, longint s, logic [63:0] d);
    logic [63:0]  mag;
    logic [127:0] num;
    logic [127:0] quo;
    logic [127:0] rem;
    logic [127:0] dd;
    logic [127:0] lim;
    mag = (s < 0) ? 64'(-s) : 64'(s);
    num = {88'd0, e} * {64'd0, mag};
    dd  = {64'd0, d};
    quo = num / dd;
    rem = num - quo * dd;
    if (rem >= dd - rem) quo = quo + 1;
    lim = (s < 0) ? (128'd1 << 47) : ((128'd1 << 47) - 1);
    if (quo > lim) quo = lim;
    return (s < 0) ? 48'(-quo) : quo[47:0];
  endfunction

  // alpha*(T-Tref) rounded to Q6.26 and saturated
  function automatic logic [31:0] thermal_expected(logic [27:0] temp);
    longint      dt;
    logic [63:0] mag;
    logic [63:0] p;
    logic [63:0] r;
    logic [63:0] lim;
    dt  = longint'({36'd0, temp}) - longint'({36'd0, tref_q});
    mag = (dt < 0) ? 64'(-dt) : 64'(dt);
    p   = {32'd0, alpha_q} * mag;
    r   = (p + (64'd1 << 25)) >> 26;
    lim = (dt < 0) ? 64'h8000_0000 : 64'h7FFF_FFFF;
    if (r > lim) r = lim;
    return (dt < 0) ? 32'(-r) : r[31:0];
  endfunction

  function automatic iesg_pkg::out_t predict_point(iesg_pkg::in_t pt);
    iesg_pkg::out_t res;
    logic [63:0] dn;
    logic [63:0] ds;
    longint      k1;
    longint      k2;
    longint      exx;
    longint      eyy;
    longint      ezz;
    longint      sxy;
    longint      sxz;
    longint      syz;
    res = '0;
    if (temp_en_q) res.thermal_strain_out = thermal_expected(pt.temperature_k);
    if (stress_en_q) begin
      dn  = ((64'd65536 + poisson_q) * (64'd65536 - 2 * poisson_q)) << 14;
      ds  = (64'd65536 + poisson_q) << 15;
      k1  = 65536 - longint'(poisson_q);
      k2  = longint'(poisson_q);
      exx = longint'(pt.dux_dx);
      eyy = longint'(pt.duy_dy);
      ezz = three_d_q ? longint'(pt.duz_dz) : 0;
      sxy = longint'(pt.dux_dy) + longint'(pt.duy_dx);
      sxz = longint'(pt.dux_dz) + longint'(pt.duz_dx);
      syz = longint'(pt.duy_dz) + longint'(pt.duz_dy);
      res.shear_strain_xy  = 32'(sxy >>> 1);
      res.normal_stress_xx = stress_quotient(youngs_q, k1 * exx + k2 * (eyy + ezz), dn);
      res.normal_stress_yy = stress_quotient(youngs_q, k1 * eyy + k2 * (exx + ezz), dn);
      res.shear_stress_xy  = stress_quotient(youngs_q, sxy, ds);
      if (three_d_q) begin
        res.shear_strain_xz  = 32'(sxz >>> 1);
        res.shear_strain_yz  = 32'(syz >>> 1);
        res.normal_stress_zz = stress_quotient(youngs_q, k1 * ezz + k2 * (exx + eyy), dn);
        res.shear_stress_xz  = stress_quotient(youngs_q, sxz, ds);
        res.shear_stress_yz  = stress_quotient(youngs_q, syz, ds);
      end
    end
    return res;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("%0t mismatch %s: got %h expected %h", $realtime, what, got, want);
    fail_count_o++;
  endtask

  task automatic compare_result(iesg_pkg::out_t got, iesg_pkg::out_t want);
    if (got.thermal_strain_out !== want.thermal_strain_out)
      report_mismatch("thermal_strain_out", 64'(got.thermal_strain_out),
                      64'(want.thermal_strain_out));
    if (got.shear_strain_xy !== want.shear_strain_xy)
      report_mismatch("shear_strain_xy", 64'(got.shear_strain_xy), 64'(want.shear_strain_xy));
    if (got.shear_strain_xz !== want.shear_strain_xz)
      report_mismatch("shear_strain_xz", 64'(got.shear_strain_xz), 64'(want.shear_strain_xz));
    if (got.shear_strain_yz !== want.shear_strain_yz)
      report_mismatch("shear_strain_yz", 64'(got.shear_strain_yz), 64'(want.shear_strain_yz));
    if (got.normal_stress_xx !== want.normal_stress_xx)
      report_mismatch("normal_stress_xx", 64'(got.normal_stress_xx), 64'(want.normal_stress_xx));
    if (got.normal_stress_yy !== want.normal_stress_yy)
      report_mismatch("normal_stress_yy", 64'(got.normal_stress_yy), 64'(want.normal_stress_yy));
    if (got.normal_stress_zz !== want.normal_stress_zz)
      report_mismatch("normal_stress_zz", 64'(got.normal_stress_zz), 64'(want.normal_stress_zz));
    if (got.shear_stress_xy !== want.shear_stress_xy)
      report_mismatch("shear_stress_xy", 64'(got.shear_stress_xy), 64'(want.shear_stress_xy));
    if (got.shear_stress_xz !== want.shear_stress_xz)
      report_mismatch("shear_stress_xz", 64'(got.shear_stress_xz), 64'(want.shear_stress_xz));
    if (got.shear_stress_yz !== want.shear_stress_yz)
      report_mismatch("shear_stress_yz", 64'(got.shear_stress_yz), 64'(want.shear_stress_yz));
  endtask

  initial begin
    fail_count_o = 0;
    pending_o    = 0;
  end

  // register writes, input beats and output beats, all sampled at the edge
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      youngs_q    = iesg_pkg::RST_YOUNGS;
      poisson_q   = iesg_pkg::RST_POISSON;
      alpha_q     = iesg_pkg::RST_ALPHA;
      tref_q      = iesg_pkg::RST_TREF;
      temp_en_q   = 1'b0;
      stress_en_q = 1'b0;
      three_d_q   = 1'b0;
      expected_results.delete();
    end else begin
      if (in_valid_i && !in_stall_i) expected_results.push_back(predict_point(in_data_i));
      if (out_valid_i && !out_stall_i) begin
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected output beat", 64'd0, 64'd0);
        end else begin
          compare_result(out_data_i, expected_results.pop_front());
        end
      end
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          iesg_pkg::CFG_YOUNGS:    youngs_q    = cfg_data_i[39:0];
          iesg_pkg::CFG_POISSON:   poisson_q   = cfg_data_i[14:0];
          iesg_pkg::CFG_ALPHA:     alpha_q     = cfg_data_i[31:0];
          iesg_pkg::CFG_TREF:      tref_q      = cfg_data_i[27:0];
          iesg_pkg::CFG_TEMP_EN:   temp_en_q   = cfg_data_i[0];
          iesg_pkg::CFG_STRESS_EN: stress_en_q = cfg_data_i[0];
          iesg_pkg::CFG_THREE_D:   three_d_q   = cfg_data_i[0];
          default: ;
        endcase
      end
    end
    pending_o = expected_results.size();
  end

endmodule

@@ dv/tb_isotropic_elastic_stress_from_gradients_core.sv @@
// ----------------------------------------------------------------------------
// tb_isotropic_elastic_stress_from_gradients_core
// Drives quadrature points and register settings into the elastic stress core,
// with random gaps and back-pressure and one long output hold-off. The checker
// beside the core does the prediction and the comparison. This module gives
// the verdict.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_isotropic_elastic_stress_from_gradients_core;

  logic                            clk;
  logic                            rst_n;
  logic                            in_valid;
  logic                            in_stall;
  iesg_pkg::in_t                   in_data;
  logic                            out_valid;
  logic                            out_stall;
  iesg_pkg::out_t                  out_data;
  logic                            cfg_valid;
  logic                            cfg_ready;
  logic [iesg_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [iesg_pkg::CFG_DATA_W-1:0] cfg_data;
  int unsigned                     fail_count;
  int unsigned                     pending;

  bit          quiet;      // no gaps on either side
  bit          hold_req;   // ask the receiver for one long hold-off
  int unsigned idle_cycles;

  isotropic_elastic_stress_from_gradients_core u_dut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_o(in_stall), .in_data_i(in_data),
    .out_valid_o(out_valid), .out_stall_i(out_stall), .out_data_o(out_data),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data)
  );

  iesg_stress_checker u_checker (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_i(in_stall), .in_data_i(in_data),
    .out_valid_i(out_valid), .out_stall_i(out_stall), .out_data_i(out_data),
    .cfg_valid_i(cfg_valid), .cfg_ready_i(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // short gaps mostly, long ones now and then
  function automatic int unsigned gap_length();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // gradient values biased towards the extremes
  function automatic logic [31:0] pick_gradient();
    case ($urandom_range(0, 9))
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      2:       return 32'h0000_0000;
      3:       return 32'hFFFF_FFFF;
      4, 5:    return 32'($signed($urandom_range(0, 2047)) - 1024);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [27:0] pick_temperature();
    case ($urandom_range(0, 5))
      0:       return 28'd0;
      1:       return 28'hFFF_FFFF;
      2:       return 28'd262144000;
      3:       return 28'd19211878 + 28'($urandom_range(0, 64)) - 28'd32;
      default: return 28'($urandom);
    endcase
  endfunction

  function automatic iesg_pkg::in_t random_point();
    iesg_pkg::in_t p;
    p.dux_dx        = pick_gradient();
    p.dux_dy        = pick_gradient();
    p.dux_dz        = pick_gradient();
    p.duy_dx        = pick_gradient();
    p.duy_dy        = pick_gradient();
    p.duy_dz        = pick_gradient();
    p.duz_dx        = pick_gradient();
    p.duz_dy        = pick_gradient();
    p.duz_dz        = pick_gradient();
    p.temperature_k = pick_temperature();
    return p;
  endfunction

  task automatic write_register(logic [iesg_pkg::CFG_IDX_W-1:0] idx,
                                logic [iesg_pkg::CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // one input beat, held until the core takes it
  task automatic send_point(iesg_pkg::in_t p);
    int unsigned g;
    g = quiet ? 0 : gap_length();
    if (g != 0) begin
      @(negedge clk);
      in_valid = 1'b0;
      repeat (g - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid = 1'b1;
    in_data  = p;
    do @(posedge clk); while (in_stall);
  endtask

  // drain the pipeline before touching the registers
  task automatic wait_idle();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (70) @(negedge clk);
  endtask

  task automatic set_material(logic [39:0] e, logic [14:0] n, logic [31:0] a, logic [27:0] t,
                              bit ten, bit sen, bit d3);
    write_register(iesg_pkg::CFG_YOUNGS, e);
    write_register(iesg_pkg::CFG_POISSON,
                   40'(({$urandom, $urandom} & ~64'h7FFF) | 64'(n)));
    write_register(iesg_pkg::CFG_ALPHA, 40'(a));
    write_register(iesg_pkg::CFG_TREF, 40'(t));
    write_register(iesg_pkg::CFG_TEMP_EN, 40'(ten));
    write_register(iesg_pkg::CFG_STRESS_EN, 40'(sen));
    write_register(iesg_pkg::CFG_THREE_D, 40'(d3));
  endtask

  function automatic logic [39:0] pick_youngs();
    case ($urandom_range(0, 5))
      0:       return 40'd0;
      1:       return 40'hFF_FFFF_FFFF;
      2:       return 40'd1000000000000;
      3:       return 40'd15000000000;
      default: return 40'({$urandom, $urandom});
    endcase
  endfunction

  function automatic logic [14:0] pick_poisson();
    case ($urandom_range(0, 4))
      0:       return 15'd0;
      1:       return 15'h7FFF;
      2:       return 15'd32112;
      default: return 15'($urandom);
    endcase
  endfunction

  // receiver: random stalls, or one long hold-off on request
  initial begin
    int unsigned len;
    out_stall = 1'b0;
    forever begin
      if (hold_req) begin
        hold_req  = 1'b0;
        out_stall = 1'b1;
        repeat (300) @(negedge clk);
      end
      len = quiet ? 1 : gap_length();
      out_stall = (len != 0) && !quiet;
      if (len == 0) len = $urandom_range(1, 12);
      repeat (len) @(negedge clk);
    end
  end

  // watchdog on cycles with no beat moving
  initial begin
    idle_cycles = 0;
    forever begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= 20000) begin
        $display("isotropic_elastic_stress_from_gradients_core test failed");
        $finish;
      end
    end
  end

  // stimulus
  initial begin
    iesg_pkg::in_t p;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    quiet     = 1'b0;
    hold_req  = 1'b0;
    rst_n     = 1'b0;
    repeat (4) @(negedge clk);
    rst_n = 1'b1;

    // reset settings: stress and temperature off
    repeat (4) send_point(random_point());
    wait_idle();

    // directed points in 3D with everything on
    set_material(40'd15000000000, 15'd13107, 32'd1099512, 28'd19211878, 1, 1, 1);
    p = '0;
    send_point(p);
    p = '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
          32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 28'hFFF_FFFF};
    send_point(p);
    p = '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
          32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 28'd0};
    send_point(p);
    p = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000,
          32'h0000_0001, 32'hFFFF_FFFF, 32'h0000_0000, 32'h7FFF_FFFF, 28'd19211878};
    send_point(p);
    // odd shear sums round towards minus infinity
    p = '{32'h0000_0001, 32'hFFFF_FFFF, 32'hFFFF_FFFE, 32'h0000_0000, 32'hFFFF_FFFF,
          32'h0000_0003, 32'hFFFF_FFFF, 32'hFFFF_FFFC, 32'h0000_0001, 28'd19211879};
    send_point(p);
    send_point(random_point());
    wait_idle();

    // saturating material: largest modulus and ratio, thermal strain overflows
    set_material(40'hFF_FFFF_FFFF, 15'h7FFF, 32'hFFFF_FFFF, 28'd0, 1, 1, 1);
    p = '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
          32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 28'hFFF_FFFF};
    send_point(p);
    p = '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
          32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 28'd0};
    send_point(p);
    repeat (4) send_point(random_point());
    wait_idle();

    // negative thermal saturation, zero modulus and ratio, 2D
    set_material(40'd0, 15'd0, 32'hFFFF_FFFF, 28'hFFF_FFFF, 1, 1, 0);
    p.temperature_k = 28'd0;
    send_point(p);
    repeat (4) send_point(random_point());
    wait_idle();

    // stress off, temperature on
    set_material(40'd1000000000000, 15'd32112, 32'd1099512, 28'd262144000, 1, 0, 1);
    repeat (4) send_point(random_point());
    wait_idle();

    // random phases; one runs gap-free and one carries the long hold-off
    for (int ph = 0; ph < 10; ph++) begin
      set_material(pick_youngs(), pick_poisson(),
                   ($urandom_range(0, 3) == 0) ? 32'hFFFF_FFFF : $urandom,
                   pick_temperature(), 1'($urandom), ($urandom_range(0, 4) != 0),
                   1'($urandom));
      quiet = (ph == 3);
      if (ph == 6) begin
        quiet    = 1'b1;
        hold_req = 1'b1;
      end
      repeat (160) send_point(random_point());
      quiet = 1'b0;
      wait_idle();
    end

    if (fail_count == 0)
      $display("isotropic_elastic_stress_from_gradients_core test passed");
    else
      $display("isotropic_elastic_stress_from_gradients_core test failed");
    $finish;
  end

endmodule
